// File: hdl/mnpt_pkg.sv
// ----------------------------------------------------------------------------
// mnpt_pkg
// Shared types and constants for the MIDI note pairing tracker: input and
// result words, the event opcode and the lookup word between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mnpt_pkg;

  localparam int unsigned NOTE_BITS       = 7;
  localparam int unsigned NOTE_COUNT      = 1 << NOTE_BITS;
  localparam int unsigned EVENT_TIME_BITS = 28;
  localparam int unsigned OUT_TIME_BITS   = 31;
  localparam int unsigned OUT_LEN_BITS    = 32;
  localparam int unsigned CALC_BITS       = 32;

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic [NOTE_BITS-1:0]       pitch;
    logic [EVENT_TIME_BITS-1:0] event_time;
  } in_word_t;

  typedef struct packed {
    logic [NOTE_BITS-1:0]            done_pitch;
    logic [OUT_TIME_BITS-1:0]        on_time;
    logic [OUT_TIME_BITS-1:0]        off_time;
    logic signed [OUT_LEN_BITS-1:0]  length;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic [NOTE_BITS-1:0] note;
    logic [CALC_BITS-1:0] on_time;
    logic [CALC_BITS-1:0] off_time;
  } lookup_t;

endpackage

`default_nettype wire

// File: hdl/midi_note_pairing_tracker.sv
// ----------------------------------------------------------------------------
// midi_note_pairing_tracker
// Pairs note on and note off events into completed notes with start time,
// end time and duration, optionally scaled by five.
//
//   channel   signals                      direction  transfer
//   event     start_i, busy_o, in_word_i   in         start_i & !busy_o
//   result    result_valid_o, result_o     out        one-cycle strobe
//   config    cfg_we_i, cfg_data_i         in         cfg_we_i
//
// One event word is taken every cycle; busy_o stays low.
// A completed note appears after its note off is taken, passing first the
// start time memory read register, then the pairing and scaling register.
// Reset clears all held marks and the emitted flag at once; the start time
// memory needs no clearing since a note without a held mark reads as zero.
// The receiver cannot stall; each result strobes for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_pairing_tracker #(
  parameter int unsigned TIME_BITS = 28
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire mnpt_pkg::in_word_t  in_word_i,
  output logic                     result_valid_o,
  output mnpt_pkg::out_word_t      result_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_data_i
);

  logic              scale_q;
  logic              accept;
  mnpt_pkg::lookup_t lookup;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  mnpt_note_table #(
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .lookup_o  (lookup)
  );

  mnpt_pair_stage u_pair (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lookup_i       (lookup),
    .scale_i        (scale_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// File: hdl/mnpt_note_table.sv
// ----------------------------------------------------------------------------
// mnpt_note_table
// Per-note start time memory with held marks. Records note on times, clears
// the held mark on note off and presents the stored start time in the cycle
// after the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mnpt_note_table #(
  parameter int unsigned TIME_BITS = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire mnpt_pkg::in_word_t in_word_i,
  output mnpt_pkg::lookup_t      lookup_o
);

  logic [TIME_BITS-1:0]             mem_q [mnpt_pkg::NOTE_COUNT];
  logic [mnpt_pkg::NOTE_COUNT-1:0]  held_q, held_d;
  logic [TIME_BITS-1:0]             rd_q;
  logic [TIME_BITS-1:0]             time_q;
  logic [TIME_BITS-1:0]             in_time;
  logic                             hit_q;
  logic                             valid_q;
  mnpt_pkg::op_e                    op_q;
  logic [mnpt_pkg::NOTE_BITS-1:0]   note_q;
  logic                             rec_en;

  assign in_time = TIME_BITS'(in_word_i.event_time);
  assign rec_en  = accept_i && (in_word_i.op == mnpt_pkg::OP_NOTE_ON)
                   && !held_q[in_word_i.pitch];

  always_comb begin
    held_d = held_q;
    if (accept_i) begin
      if (in_word_i.op == mnpt_pkg::OP_NOTE_ON) begin
        held_d[in_word_i.pitch] = 1'b1;
      end else begin
        held_d[in_word_i.pitch] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      held_q  <= held_d;
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_en) begin
      mem_q[in_word_i.pitch] <= in_time;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q   <= mem_q[in_word_i.pitch];
      hit_q  <= held_q[in_word_i.pitch];
      op_q   <= in_word_i.op;
      note_q <= in_word_i.pitch;
      time_q <= in_time;
    end
  end

  always_comb begin
    lookup_o.valid    = valid_q;
    lookup_o.op       = op_q;
    lookup_o.note     = note_q;
    lookup_o.on_time  = hit_q ? mnpt_pkg::CALC_BITS'(rd_q) : '0;
    lookup_o.off_time = mnpt_pkg::CALC_BITS'(time_q);
  end

endmodule

`default_nettype wire

// File: hdl/mnpt_pair_stage.sv
// ----------------------------------------------------------------------------
// mnpt_pair_stage
// Decides whether a note off completes a note, applies the optional times
// five scaling and registers the result word with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mnpt_pair_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mnpt_pkg::lookup_t  lookup_i,
  input  wire logic               scale_i,
  output logic                    result_valid_o,
  output mnpt_pkg::out_word_t     result_o
);

  logic                           any_emitted_q, any_emitted_d;
  logic                           valid_q, valid_d;
  mnpt_pkg::out_word_t            out_q, out_d;
  logic                           emit;
  logic [mnpt_pkg::CALC_BITS-1:0] diff;
  logic [mnpt_pkg::CALC_BITS-1:0] on_s;
  logic [mnpt_pkg::CALC_BITS-1:0] off_s;
  logic [mnpt_pkg::CALC_BITS-1:0] len_s;

  assign emit = lookup_i.valid && (lookup_i.op == mnpt_pkg::OP_NOTE_OFF)
                && ((lookup_i.on_time != '0) || !any_emitted_q);
  assign diff = lookup_i.off_time - lookup_i.on_time;

  // times five as shift and add
  assign on_s  = scale_i ? ((lookup_i.on_time << 2) + lookup_i.on_time) : lookup_i.on_time;
  assign off_s = scale_i ? ((lookup_i.off_time << 2) + lookup_i.off_time) : lookup_i.off_time;
  assign len_s = scale_i ? ((diff << 2) + diff) : diff;

  always_comb begin
    any_emitted_d       = any_emitted_q | emit;
    valid_d             = emit;
    out_d.done_pitch    = lookup_i.note;
    out_d.on_time       = on_s[mnpt_pkg::OUT_TIME_BITS-1:0];
    out_d.off_time      = off_s[mnpt_pkg::OUT_TIME_BITS-1:0];
    out_d.length        = signed'(len_s[mnpt_pkg::OUT_LEN_BITS-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_emitted_q <= 1'b0;
      valid_q       <= 1'b0;
    end else begin
      any_emitted_q <= any_emitted_d;
      valid_q       <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire
